### rtl/core/tps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

    localparam int          MAX_TRIG_WORDS_DEF = 4;
    localparam logic [31:0] IDLE_CONST         = 32'h7855_7855;
    localparam int          SEQ_STEPS          = 16;
    localparam int          STEP_W             = 4;
    localparam int          CFG_IDX_W          = 3;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_ENABLE = 3'd1,
        MODE_ABORT  = 3'd2,
        MODE_LOAD   = 3'd3,
        MODE_CMD    = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIG_MODE   = 3'd0,
        CFG_TRIG_COUNT  = 3'd1,
        CFG_PERIOD      = 3'd2,
        CFG_DURATION    = 3'd3,
        CFG_WORD_LENGTH = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DECIDE,
        S_RDWORD,
        S_LOADWORD,
        S_SHIFT,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic        load;
        logic        step;
        logic [31:0] word;
    } t_ser_ctl;

    typedef struct packed {
        logic [3:0] nibble;
        logic       final_step;
    } t_ser_sts;

endpackage

`default_nettype wire

### rtl/core/tps_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tps_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [1:0]  word_index;
    logic [31:0] data;
    modport source (output valid, mode, word_index, data, input ready);
    modport sink   (input valid, mode, word_index, data, output ready);
endinterface

interface tps_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] seq_nibble;
    logic       seq_valid;
    logic       last;
    logic       trig_active;
    modport source (output valid, seq_nibble, seq_valid, last, trig_active, input ready);
    modport sink   (input valid, seq_nibble, seq_valid, last, trig_active, output ready);
endinterface

interface tps_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tps_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/tps_word_store.sv
`timescale 1ns / 1ps
`default_nettype none

module tps_word_store #(
    parameter int MAX_TRIG_WORDS = tps_pkg::MAX_TRIG_WORDS_DEF,
    localparam int IDX_W = (MAX_TRIG_WORDS > 1) ? $clog2(MAX_TRIG_WORDS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  wire logic [31:0]      i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output logic      [31:0]      o_rd_data
);

    logic [31:0] r_mem [MAX_TRIG_WORDS];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/core/tps_serializer.sv
`timescale 1ns / 1ps
`default_nettype none

module tps_serializer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tps_pkg::t_ser_ctl i_ctl,
    output tps_pkg::t_ser_sts      o_sts
);

    logic [31:0]                r_cmd;
    logic [31:0]                r_idl;
    logic [tps_pkg::STEP_W-1:0] r_cnt;

    // one bit pair of each word per step, MSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= '0;
        end else if (i_ctl.step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_ctl.word;
            r_idl <= tps_pkg::IDLE_CONST;
        end else if (i_ctl.step) begin
            r_cmd <= {r_cmd[29:0], 2'b00};
            r_idl <= {r_idl[29:0], 2'b00};
        end
    end

    assign o_sts.nibble     = {r_idl[31:30], r_cmd[31:30]};
    assign o_sts.final_step = (r_cnt == tps_pkg::STEP_W'(tps_pkg::SEQ_STEPS - 1));

endmodule

`default_nettype wire

### rtl/core/trigger_pattern_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Periodic trigger pattern sequencer. One input transaction is taken at a
// time: ready is high only while the sequencer is idle. A control
// transaction (idle tick, abort, load, enable with zero data, undefined mode)
// returns one status result. A firing returns 16 results per trigger word
// in use, last word first, one per cycle within a word while the output is
// not stalled, through a single 2-bit shift serializer; each word takes a
// registered word store read, a load and 16 shifts. A command word is loaded
// straight into the serializer and gives 16 results. trig_active on every
// result is the run state after its input has been handled. The output
// register lets the next transaction be accepted while the final result
// still waits to be taken.
module trigger_pattern_sequencer #(
    parameter int MAX_TRIG_WORDS = tps_pkg::MAX_TRIG_WORDS_DEF
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    tps_in_if.sink     i_in,
    tps_out_if.source  o_out,
    tps_cfg_if.sink    i_cfg
);

    localparam int IDX_W = (MAX_TRIG_WORDS > 1) ? $clog2(MAX_TRIG_WORDS) : 1;
    localparam logic [2:0] MAX_W = 3'(MAX_TRIG_WORDS);

    // configuration
    logic        r_trig_mode;
    logic [31:0] r_trig_count;
    logic [31:0] r_period;
    logic [31:0] r_duration;
    logic [2:0]  r_word_length;

    // run state
    tps_pkg::t_state r_state, n_state;
    logic [2:0]  r_loaded, n_loaded;
    logic        r_run, n_run;
    logic [31:0] r_remaining, n_remaining;
    logic [31:0] r_timer, n_timer;
    logic [31:0] r_elapsed, n_elapsed;
    logic [IDX_W-1:0] r_widx, n_widx;
    logic        r_is_cmd, n_is_cmd;

    // latched input
    logic [2:0]  r_in_mode;
    logic [1:0]  r_in_idx;
    logic [31:0] r_in_data;

    // output register
    logic        r_ov, n_ov;
    logic [3:0]  r_o_word, n_o_word;
    logic        r_o_sv, n_o_sv;
    logic        r_o_last, n_o_last;
    logic        r_o_act, n_o_act;

    logic              in_acc;
    logic              out_free;
    logic [2:0]        wl_sat;
    logic [2:0]        used;
    logic [31:0]       reload;
    logic              wr_en;
    logic              rd_en;
    logic [31:0]       rd_data;
    tps_pkg::t_ser_ctl ser_ctl;
    tps_pkg::t_ser_sts ser_sts;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;
    assign wl_sat   = (r_word_length > MAX_W) ? MAX_W : r_word_length;
    assign used     = (wl_sat > r_loaded) ? r_loaded : wl_sat;
    assign reload   = (r_period == 32'd0) ? 32'd1 : r_period;

    assign i_in.ready  = (r_state == tps_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_ov;
    assign o_out.seq_nibble  = r_o_word;
    assign o_out.seq_valid   = r_o_sv;
    assign o_out.last        = r_o_last;
    assign o_out.trig_active = r_o_act;

    tps_word_store #(
        .MAX_TRIG_WORDS(MAX_TRIG_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_in_idx[IDX_W-1:0]),
        .i_wr_data (r_in_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_widx),
        .o_rd_data (rd_data)
    );

    tps_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ser_ctl),
        .o_sts   (ser_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_mode   <= 1'b0;
            r_trig_count  <= '0;
            r_period      <= 32'd1;
            r_duration    <= '0;
            r_word_length <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                tps_pkg::CFG_TRIG_MODE:   r_trig_mode   <= i_cfg.data[0];
                tps_pkg::CFG_TRIG_COUNT:  r_trig_count  <= i_cfg.data;
                tps_pkg::CFG_PERIOD:      r_period      <= i_cfg.data;
                tps_pkg::CFG_DURATION:    r_duration    <= i_cfg.data;
                tps_pkg::CFG_WORD_LENGTH: r_word_length <= i_cfg.data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_mode <= i_in.mode;
            r_in_idx  <= i_in.word_index;
            r_in_data <= i_in.data;
        end
        r_o_word <= n_o_word;
        r_o_sv   <= n_o_sv;
        r_o_last <= n_o_last;
        r_o_act  <= n_o_act;
        r_widx   <= n_widx;
        r_is_cmd <= n_is_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tps_pkg::S_IDLE;
            r_loaded    <= '0;
            r_run       <= 1'b0;
            r_remaining <= '0;
            r_timer     <= '0;
            r_elapsed   <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_run       <= n_run;
            r_remaining <= n_remaining;
            r_timer     <= n_timer;
            r_elapsed   <= n_elapsed;
            r_ov        <= n_ov;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_run       = r_run;
        n_remaining = r_remaining;
        n_timer     = r_timer;
        n_elapsed   = r_elapsed;
        n_widx      = r_widx;
        n_is_cmd    = r_is_cmd;
        n_ov        = r_ov && !o_out.ready;
        n_o_word    = r_o_word;
        n_o_sv      = r_o_sv;
        n_o_last    = r_o_last;
        n_o_act     = r_o_act;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        ser_ctl     = '{load: 1'b0, step: 1'b0, word: r_in_data};

        case (r_state)
            tps_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = tps_pkg::S_EXEC;
                end
            end

            tps_pkg::S_EXEC: begin
                n_state  = tps_pkg::S_STATUS;
                n_is_cmd = 1'b0;
                case (r_in_mode)
                    tps_pkg::MODE_TICK: begin
                        if (r_run) begin
                            if (r_elapsed != 32'hFFFF_FFFF) begin
                                n_elapsed = r_elapsed + 32'd1;
                            end
                            if (r_timer > 32'd1) begin
                                n_timer = r_timer - 32'd1;
                            end else begin
                                n_timer = '0;
                                n_state = tps_pkg::S_DECIDE;
                            end
                        end
                    end
                    tps_pkg::MODE_ENABLE: begin
                        n_run       = 1'b0;
                        if (r_in_data != 32'd0) begin
                            n_elapsed   = '0;
                            n_remaining = '0;
                            n_timer     = '0;
                            if (r_trig_mode ? (r_duration != 32'd0)
                                            : (r_trig_count != 32'd0)) begin
                                if (!r_trig_mode) begin
                                    n_remaining = r_trig_count - 32'd1;
                                end
                                n_run   = 1'b1;
                                n_timer = reload;
                                if (used != 3'd0) begin
                                    n_widx  = IDX_W'(used - 3'd1);
                                    n_state = tps_pkg::S_RDWORD;
                                end
                            end
                        end
                    end
                    tps_pkg::MODE_ABORT: begin
                        n_run = 1'b0;
                    end
                    tps_pkg::MODE_LOAD: begin
                        if ({1'b0, r_in_idx} < MAX_W) begin
                            wr_en = 1'b1;
                            if (r_loaded < ({1'b0, r_in_idx} + 3'd1)) begin
                                n_loaded = {1'b0, r_in_idx} + 3'd1;
                            end
                        end
                    end
                    tps_pkg::MODE_CMD: begin
                        ser_ctl.load = 1'b1;
                        n_is_cmd     = 1'b1;
                        n_state      = tps_pkg::S_SHIFT;
                    end
                    default: ;
                endcase
            end

            tps_pkg::S_DECIDE: begin
                // period end: fire again or stop
                n_state = tps_pkg::S_STATUS;
                if (r_trig_mode ? (r_elapsed >= r_duration)
                                : (r_remaining == 32'd0)) begin
                    n_run = 1'b0;
                end else begin
                    if (!r_trig_mode) begin
                        n_remaining = r_remaining - 32'd1;
                    end
                    n_timer = reload;
                    if (used != 3'd0) begin
                        n_widx  = IDX_W'(used - 3'd1);
                        n_state = tps_pkg::S_RDWORD;
                    end
                end
            end

            tps_pkg::S_RDWORD: begin
                rd_en   = 1'b1;
                n_state = tps_pkg::S_LOADWORD;
            end

            tps_pkg::S_LOADWORD: begin
                ser_ctl.load = 1'b1;
                ser_ctl.word = rd_data;
                n_state      = tps_pkg::S_SHIFT;
            end

            tps_pkg::S_SHIFT: begin
                if (out_free) begin
                    n_ov         = 1'b1;
                    n_o_word     = ser_sts.nibble;
                    n_o_sv       = 1'b1;
                    n_o_act      = r_run;
                    n_o_last     = ser_sts.final_step && (r_is_cmd || r_widx == '0);
                    ser_ctl.step = 1'b1;
                    if (ser_sts.final_step) begin
                        if (r_is_cmd || r_widx == '0) begin
                            n_state = tps_pkg::S_IDLE;
                        end else begin
                            n_widx  = r_widx - 1'b1;
                            n_state = tps_pkg::S_RDWORD;
                        end
                    end
                end
            end

            tps_pkg::S_STATUS: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_o_word = '0;
                    n_o_sv   = 1'b0;
                    n_o_last = 1'b1;
                    n_o_act  = r_run;
                    n_state  = tps_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tps_pkg::S_IDLE;
            end
        endcase
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("input accepted while a transaction is in progress");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.seq_valid) |-> (o_out.last && o_out.seq_nibble == 4'd0))
        else $error("status result not marked last or carries data");

    a_shift_only_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tps_pkg::S_SHIFT) |-> ($past(r_state) == tps_pkg::S_SHIFT ||
        $past(r_state) == tps_pkg::S_LOADWORD || $past(r_state) == tps_pkg::S_EXEC))
        else $error("serializer shifting without a loaded word");

    a_out_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tps_pkg::S_SHIFT && !out_free) |=> $stable(r_widx))
        else $error("word index moved during output stall");

endmodule

`default_nettype wire
